@@ design/hpid_pkg.sv @@
// Package for the heater PID controller with full-power bypass.
// Field widths, register indexes, reset values and shared structs.
// No dependencies.
package hpid_pkg;

    localparam int TEMP_W    = 11;  // measured temperature, signed
    localparam int TGT_W     = 10;
    localparam int ERR_W     = 12;  // target minus sample, signed
    localparam int DIFF_W    = 13;  // difference of two errors, signed
    localparam int GAIN_W    = 12;
    localparam int THR_W     = 8;
    localparam int LIMIT_W   = 16;  // integral limit and error sum
    localparam int DRIVE_W   = 16;
    localparam int BAND_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DIFF_TAPS_DEF = 4;

    localparam int INTEGRAL_PRESET = 800;
    localparam int RESUME_MARGIN   = 10;

    localparam logic [TGT_W-1:0]   TARGET_RST    = 10'd240;
    localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 12'd800;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 12'd25;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 12'd700;
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 8'd15;
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 16'd1500;
    localparam logic [DRIVE_W-1:0] OUT_MAX_RST   = 16'd40000;
    localparam logic [BAND_W-1:0]  REACH_RST     = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET    = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_THRESHOLD = 3'd4,
        REG_LIMIT     = 3'd5,
        REG_OUT_MAX   = 3'd6,
        REG_REACH     = 3'd7
    } cfg_reg_t;

    // settings used by the error/state update stage
    typedef struct packed {
        logic [TGT_W-1:0]   target;
        logic [THR_W-1:0]   threshold;
        logic [LIMIT_W-1:0] limit;
        logic [BAND_W-1:0]  reach;
    } upd_cfg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] p;
        logic [GAIN_W-1:0] i;
        logic [GAIN_W-1:0] d;
    } gain_t;

    // per-item status that rides along the pipeline
    typedef struct packed {
        logic bypass;
        logic at_target;
    } ctl_t;

endpackage

@@ design/hpid_update.sv @@
// Error and controller state update for the heater PID block.
// Holds bypass mode, error sum, last error and the difference window.
// Depends on hpid_pkg.
module hpid_update #(
    parameter int DIFF_TAPS = hpid_pkg::DIFF_TAPS_DEF,
    parameter int DSUM_W    = hpid_pkg::DIFF_W + $clog2(hpid_pkg::DIFF_TAPS_DEF)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic signed [hpid_pkg::TEMP_W-1:0]  sample,
    input  hpid_pkg::upd_cfg_t                  cfg,
    output logic signed [hpid_pkg::ERR_W-1:0]   err,
    output logic [hpid_pkg::LIMIT_W-1:0]        esum,
    output logic signed [DSUM_W-1:0]            dsum,
    output hpid_pkg::ctl_t                      flags
);
    import hpid_pkg::*;

    localparam int IDX_W   = (DIFF_TAPS > 1) ? $clog2(DIFF_TAPS) : 1;
    localparam int DSUM_XW = DSUM_W + 1;
    localparam int ESUM_XW = LIMIT_W + 2;

    logic                      bypass_reg;
    logic [LIMIT_W-1:0]        esum_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic signed [DIFF_W-1:0]  win_reg [DIFF_TAPS];
    logic signed [DSUM_W-1:0]  dsum_reg;
    logic [IDX_W-1:0]          idx_reg;

    logic                      bypass_next;
    logic                      clear;
    logic signed [ERR_W-1:0]   thr_s;
    logic signed [ERR_W-1:0]   resume_s;
    logic signed [ERR_W-1:0]   band_s;
    logic [LIMIT_W-1:0]        esum_base;
    logic signed [ESUM_XW-1:0] esum_wide;
    logic signed [ESUM_XW-1:0] limit_s;
    logic [LIMIT_W-1:0]        esum_next;
    logic signed [ERR_W-1:0]   prev_err;
    logic signed [DIFF_W-1:0]  diff;
    logic [IDX_W-1:0]          slot;
    logic signed [DIFF_W-1:0]  old_val;
    logic signed [DSUM_W-1:0]  old_sum;
    logic signed [DSUM_XW-1:0] dsum_wide;
    logic signed [DSUM_W-1:0]  dsum_next;
    logic [IDX_W-1:0]          idx_next;

    always_comb
    begin
        err      = $signed({2'b00, cfg.target}) - ERR_W'(sample);
        thr_s    = $signed({4'b0000, cfg.threshold});
        resume_s = thr_s + ERR_W'(RESUME_MARGIN);
        band_s   = $signed({4'b0000, cfg.reach});

        // hysteresis: leaving bypass also restarts the PID terms
        clear       = bypass_reg && (err < thr_s);
        bypass_next = bypass_reg;
        if (clear)
        begin
            bypass_next = 1'b0;
        end
        else if (!bypass_reg && (err > resume_s))
        begin
            bypass_next = 1'b1;
        end

        esum_base = clear ? LIMIT_W'(INTEGRAL_PRESET) : esum_reg;
        esum_wide = $signed({2'b00, esum_base}) + ESUM_XW'(err);
        limit_s   = $signed({2'b00, cfg.limit});
        if (esum_wide > limit_s)
        begin
            esum_next = cfg.limit;
        end
        else if (esum_wide < 0)
        begin
            esum_next = '0;
        end
        else
        begin
            esum_next = esum_wide[LIMIT_W-1:0];
        end

        prev_err  = clear ? '0 : last_err_reg;
        diff      = DIFF_W'(err) - DIFF_W'(prev_err);
        slot      = clear ? '0 : idx_reg;
        old_val   = clear ? '0 : win_reg[slot];
        old_sum   = clear ? '0 : dsum_reg;
        dsum_wide = DSUM_XW'(old_sum) - DSUM_XW'(old_val) + DSUM_XW'(diff);
        dsum_next = dsum_wide[DSUM_W-1:0];
        idx_next  = (slot == IDX_W'(DIFF_TAPS - 1)) ? '0 : slot + 1'b1;

        esum            = esum_next;
        dsum            = dsum_next;
        flags.bypass    = bypass_next;
        flags.at_target = (err <= band_s) && (err >= -band_s);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg   <= 1'b1;
            esum_reg     <= '0;
            last_err_reg <= '0;
            dsum_reg     <= '0;
            idx_reg      <= '0;
            for (int k = 0; k < DIFF_TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            bypass_reg <= bypass_next;
            // bypass leaves the PID state alone
            if (!bypass_next)
            begin
                esum_reg     <= esum_next;
                last_err_reg <= err;
                dsum_reg     <= dsum_next;
                idx_reg      <= idx_next;
                for (int k = 0; k < DIFF_TAPS; k++)
                begin
                    if (IDX_W'(k) == slot)
                    begin
                        win_reg[k] <= diff;
                    end
                    else if (clear)
                    begin
                        win_reg[k] <= '0;
                    end
                end
            end
        end
    end

endmodule

@@ design/hpid_mac.sv @@
// Gain multiply and output clamp for the heater PID block.
// Registers the three products, then sums and clamps them to the full-scale drive.
// Depends on hpid_pkg.
module hpid_mac #(
    parameter int DSUM_W = hpid_pkg::DIFF_W + $clog2(hpid_pkg::DIFF_TAPS_DEF)
) (
    input  logic                               clk,
    input  logic                               load,
    input  hpid_pkg::gain_t                    gain,
    input  logic signed [hpid_pkg::ERR_W-1:0]  err,
    input  logic [hpid_pkg::LIMIT_W-1:0]       esum,
    input  logic signed [DSUM_W-1:0]           dsum,
    input  logic [hpid_pkg::DRIVE_W-1:0]       out_max,
    output logic [hpid_pkg::DRIVE_W-1:0]       pid_drive
);
    import hpid_pkg::*;

    localparam int P_W   = ERR_W + GAIN_W + 1;
    localparam int I_W   = LIMIT_W + GAIN_W;
    localparam int D_W   = DSUM_W + GAIN_W + 1;
    localparam int MAX_A = (P_W > I_W + 1) ? P_W : I_W + 1;
    localparam int MAX_W = (MAX_A > D_W) ? MAX_A : D_W;
    localparam int TOT_W = MAX_W + 2;

    logic signed [P_W-1:0]   prod_p_reg;
    logic [I_W-1:0]          prod_i_reg;
    logic signed [D_W-1:0]   prod_d_reg;
    logic signed [TOT_W-1:0] total;
    logic signed [TOT_W-1:0] max_s;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_p_reg <= $signed({1'b0, gain.p}) * err;
            prod_i_reg <= gain.i * esum;
            prod_d_reg <= $signed({1'b0, gain.d}) * dsum;
        end
    end

    always_comb
    begin
        total = TOT_W'(prod_p_reg) + TOT_W'($signed({1'b0, prod_i_reg}))
              + TOT_W'(prod_d_reg);
        max_s = $signed(TOT_W'(out_max));
        if (total < 0)
        begin
            pid_drive = '0;
        end
        else if (total > max_s)
        begin
            pid_drive = out_max;
        end
        else
        begin
            pid_drive = total[DRIVE_W-1:0];
        end
    end

endmodule

@@ design/heater_pid_with_bypass.sv @@
// Heater temperature controller: PID with a full-power bypass that has hysteresis.
// Top level: stream channels, settings registers, three-stage pipeline.
// Depends on hpid_pkg, hpid_update and hpid_mac.
//
// Usage:
//   One temperature sample per transfer enters on s_tdata; one result per sample
//   leaves on m_tdata (heater drive) with m_tuser carrying bypass and at-target.
//   Settings are written through cfg_wr_en/cfg_index/cfg_data while no sample is
//   in flight; index 0..7 selects target, gains P/I/D, bypass threshold,
//   integral limit, full-scale drive and reach band.
//   An input transfer loads the error and state update stage; the result then
//   passes through the gain multiply stage and the sum and clamp stage, which
//   drives m_tvalid, before it can transfer out while m_tready is high.
//   Throughput is one sample per cycle unless the receiver stalls; each state update completes as its sample is taken.
//   Each stage holds when the one after it is full and blocked, so a stalled
//   receiver fills the pipeline; s_tready drops only when all three stages
//   hold items. Nothing is lost or repeated.
//   Reset (rst_n low) empties the pipeline, loads the default settings, enters
//   bypass mode and clears the integral and difference window.
module heater_pid_with_bypass #(
    parameter int DIFF_TAPS = hpid_pkg::DIFF_TAPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,   // [10:0] temp_sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,   // [15:0] heater_drive
    output logic [1:0]                           m_tuser,   // [0] bypass_active, [1] at_target
    input  logic                                 cfg_wr_en,
    input  logic [hpid_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hpid_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import hpid_pkg::*;

    localparam int DSUM_W = DIFF_W + $clog2(DIFF_TAPS);

    // settings
    logic [TGT_W-1:0]   target_reg;
    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [GAIN_W-1:0]  gain_d_reg;
    logic [THR_W-1:0]   threshold_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [DRIVE_W-1:0] out_max_reg;
    logic [BAND_W-1:0]  reach_reg;

    // pipeline
    logic                      v1_reg, v2_reg, v3_reg;
    logic                      v1_next, v2_next, v3_next;
    logic                      r1, r2, r3;
    logic                      advance;
    logic signed [ERR_W-1:0]   err_reg;
    logic [LIMIT_W-1:0]        esum_reg;
    logic signed [DSUM_W-1:0]  dsum_reg;
    ctl_t                      ctl1_reg, ctl2_reg, ctl3_reg;
    logic [DRIVE_W-1:0]        drive_reg;

    upd_cfg_t                  upd_cfg;
    gain_t                     gains;
    logic signed [ERR_W-1:0]   err_c;
    logic [LIMIT_W-1:0]        esum_c;
    logic signed [DSUM_W-1:0]  dsum_c;
    ctl_t                      ctl_c;
    logic [DRIVE_W-1:0]        pid_drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TARGET_RST;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            threshold_reg <= THRESHOLD_RST;
            limit_reg     <= LIMIT_RST;
            out_max_reg   <= OUT_MAX_RST;
            reach_reg     <= REACH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET:    target_reg    <= cfg_data[TGT_W-1:0];
                REG_GAIN_P:    gain_p_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:    gain_i_reg    <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:    gain_d_reg    <= cfg_data[GAIN_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                REG_LIMIT:     limit_reg     <= cfg_data[LIMIT_W-1:0];
                REG_OUT_MAX:   out_max_reg   <= cfg_data[DRIVE_W-1:0];
                REG_REACH:     reach_reg     <= cfg_data[BAND_W-1:0];
                default:       ;
            endcase
        end
    end

    // a stage may load when it is empty or its item moves on this cycle
    always_comb
    begin
        r3       = !v3_reg || m_tready;
        r2       = !v2_reg || r3;
        r1       = !v1_reg || r2;
        s_tready = r1;
        advance  = s_tvalid && r1;
        v1_next  = r1 ? s_tvalid : v1_reg;
        v2_next  = r2 ? v1_reg : v2_reg;
        v3_next  = r3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign upd_cfg.target    = target_reg;
    assign upd_cfg.threshold = threshold_reg;
    assign upd_cfg.limit     = limit_reg;
    assign upd_cfg.reach     = reach_reg;

    hpid_update #(
        .DIFF_TAPS (DIFF_TAPS),
        .DSUM_W    (DSUM_W)
    ) u_update (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  ($signed(s_tdata[TEMP_W-1:0])),
        .cfg     (upd_cfg),
        .err     (err_c),
        .esum    (esum_c),
        .dsum    (dsum_c),
        .flags   (ctl_c)
    );

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            err_reg  <= err_c;
            esum_reg <= esum_c;
            dsum_reg <= dsum_c;
            ctl1_reg <= ctl_c;
        end
        if (r2)
        begin
            ctl2_reg <= ctl1_reg;
        end
        if (r3)
        begin
            ctl3_reg  <= ctl2_reg;
            drive_reg <= ctl2_reg.bypass ? out_max_reg : pid_drive;
        end
    end

    assign gains.p = gain_p_reg;
    assign gains.i = gain_i_reg;
    assign gains.d = gain_d_reg;

    hpid_mac #(
        .DSUM_W (DSUM_W)
    ) u_mac (
        .clk       (clk),
        .load      (r2),
        .gain      (gains),
        .err       (err_reg),
        .esum      (esum_reg),
        .dsum      (dsum_reg),
        .out_max   (out_max_reg),
        .pid_drive (pid_drive)
    );

    assign m_tvalid   = v3_reg;
    assign m_tdata    = drive_reg;
    assign m_tuser[0] = ctl3_reg.bypass;
    assign m_tuser[1] = ctl3_reg.at_target;

`ifndef SYNTHESIS
    // an empty pipeline always takes a sample
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg && !v2_reg && !v3_reg) |-> s_tready)
        else $error("input blocked with empty pipeline");

    // an item in the multiply stage reaches the output when the output can load
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && r3) |=> m_tvalid)
        else $error("item lost between multiply and output stage");

    // no transfer in while every stage is full and the receiver stalls
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !m_tready) |-> !s_tready)
        else $error("input accepted into a full pipeline");
`endif

endmodule

@@ dv/heater_drive_checker.sv @@
// Result checker for heater_pid_with_bypass: watches the sample, result and
// settings ports, predicts every result and compares it with what arrives.
// Depends on hpid_pkg.
module heater_drive_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,    // [10:0] temp_sample
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [15:0]                     m_tdata,    // [15:0] heater_drive
    input  logic [1:0]                      m_tuser,    // [0] bypass_active, [1] at_target
    input  logic                            cfg_wr_en,
    input  logic [hpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpid_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import hpid_pkg::*;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               bypass;
        logic               at_target;
    } drive_t;

    drive_t drive_q[$];

    // local copy of the settings registers
    logic [TGT_W-1:0]   target;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [THR_W-1:0]   threshold;
    logic [LIMIT_W-1:0] limit;
    logic [DRIVE_W-1:0] out_max;
    logic [BAND_W-1:0]  reach;

    // controller state
    logic bypass_on;
    int   err_sum;
    int   last_err;
    int   diff_win [DIFF_TAPS_DEF];
    int   diff_sum;
    int   slot;
    int   errs;

    function automatic drive_t next_drive(input logic [TEMP_W-1:0] raw);
        logic signed [TEMP_W-1:0] t;
        int     s;
        int     e;
        int     thr;
        int     d;
        longint total;
        drive_t r;
        t   = raw;
        s   = t;
        e   = int'(target) - s;
        thr = int'(threshold);
        if (bypass_on && e < thr)
        begin
            // hand-over to PID starts from a fresh state with the integral preset
            bypass_on = 1'b0;
            err_sum   = INTEGRAL_PRESET;
            last_err  = 0;
            foreach (diff_win[k])
                diff_win[k] = 0;
            diff_sum  = 0;
            slot      = 0;
        end
        else if (!bypass_on && e > thr + RESUME_MARGIN)
        begin
            bypass_on = 1'b1;
        end
        if (bypass_on)
        begin
            r.drive = out_max;
        end
        else
        begin
            err_sum += e;
            if (err_sum > int'(limit))
                err_sum = int'(limit);
            if (err_sum < 0)
                err_sum = 0;
            d              = e - last_err;
            diff_sum       = diff_sum - diff_win[slot] + d;
            diff_win[slot] = d;
            slot           = (slot + 1) % DIFF_TAPS_DEF;
            last_err       = e;
            total = longint'(gain_p) * e + longint'(gain_i) * err_sum
                  + longint'(gain_d) * diff_sum;
            if (total < 0)
                total = 0;
            if (total > longint'(out_max))
                total = longint'(out_max);
            r.drive = total[DRIVE_W-1:0];
        end
        r.bypass    = bypass_on;
        r.at_target = (s >= int'(target) - int'(reach)) && (s <= int'(target) + int'(reach));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_ports
        drive_t got;
        drive_t want;
        if (!rst_n)
        begin
            target     = TARGET_RST;
            gain_p     = GAIN_P_RST;
            gain_i     = GAIN_I_RST;
            gain_d     = GAIN_D_RST;
            threshold  = THRESHOLD_RST;
            limit      = LIMIT_RST;
            out_max    = OUT_MAX_RST;
            reach      = REACH_RST;
            bypass_on  = 1'b1;
            err_sum    = 0;
            last_err   = 0;
            foreach (diff_win[k])
                diff_win[k] = 0;
            diff_sum   = 0;
            slot       = 0;
            errs       = 0;
            drive_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.drive     = m_tdata;
                got.bypass    = m_tuser[0];
                got.at_target = m_tuser[1];
                if (drive_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result: drive=%0d bypass=%b at_target=%b",
                             $time, got.drive, got.bypass, got.at_target);
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got !== want)
                    begin
                        errs++;
                        $display("%0t: mismatch: expected drive=%0d bypass=%b at_target=%b",
                                 $time, want.drive, want.bypass, want.at_target,
                                 ", actual drive=%0d bypass=%b at_target=%b",
                                 got.drive, got.bypass, got.at_target);
                    end
                end
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(next_drive(s_tdata[TEMP_W-1:0]));
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_TARGET:    target    = cfg_data[TGT_W-1:0];
                    REG_GAIN_P:    gain_p    = cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:    gain_i    = cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:    gain_d    = cfg_data[GAIN_W-1:0];
                    REG_THRESHOLD: threshold = cfg_data[THR_W-1:0];
                    REG_LIMIT:     limit     = cfg_data[LIMIT_W-1:0];
                    REG_OUT_MAX:   out_max   = cfg_data[DRIVE_W-1:0];
                    REG_REACH:     reach     = cfg_data[BAND_W-1:0];
                    default:       ;
                endcase
            end
            fail_count <= errs;
            pending    <= drive_q.size();
        end
    end

endmodule

@@ dv/heater_pid_with_bypass_tb.sv @@
// Testbench top for heater_pid_with_bypass: clock, reset, sample and settings
// stimulus with varying back-pressure, and the final verdict.
// Depends on hpid_pkg, heater_pid_with_bypass and heater_drive_checker.
module heater_pid_with_bypass_tb;
    import hpid_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 136;

    typedef enum int {
        PACE_FULL,
        PACE_SRC_IDLE,
        PACE_SINK_STALL,
        PACE_BOTH
    } pace_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int    fail_count;
    int    pending;
    pace_t pace     = PACE_FULL;
    bit    hold_req = 1'b0;
    int    tgt_now  = 240;
    int    thr_now  = 15;
    int    walk     = 240;

    // hysteresis edges, reach-band edges and full-range extremes at reset settings
    int directed_temps [0:21] = '{-512, 1023, 0, 226, 214, 215, 225, 226, 215, 230, 236,
                                  235, 244, 245, 240, 240, 240, 250, 1023, -1, 512, 225};

    heater_pid_with_bypass uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    heater_drive_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver side: random stalls by pace, or one long hold-off on request
    initial
    begin
        int sink_pct;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                sink_pct = (pace == PACE_SINK_STALL) ? 74 : (pace == PACE_BOTH) ? 11 : 0;
                m_tready <= (int'($urandom_range(0, 99)) >= sink_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("** heater_pid_with_bypass: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_temp(input int t);
        int src_pct;
        src_pct = (pace == PACE_SRC_IDLE) ? 74 : (pace == PACE_BOTH) ? 11 : 0;
        while (int'($urandom_range(0, 99)) < src_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, 11'(t)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(val);
        @(posedge clk);
    endtask

    task automatic load_settings(input int tgt, input int gp, input int gi, input int gd,
                                 input int thr, input int lim, input int omax,
                                 input int band);
        write_reg(REG_TARGET, tgt);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_OUT_MAX, omax);
        write_reg(REG_REACH, band);
        cfg_wr_en <= 1'b0;
        tgt_now = tgt & 'h3FF;
        thr_now = thr & 'hFF;
    endtask

    task automatic pick_settings(input int ph);
        case (ph)
            1: load_settings(0, 0, 0, 0, 0, 0, 0, 0);
            2: load_settings(1023, 4095, 4095, 4095, 255, 65535, 65535, 255);
            // limit below the integral preset, products far past full scale
            3: load_settings(300, 4095, 4095, 4095, 20, 100, 65535, 3);
            default:
                if (ph % 2)
                    load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535));
                else
                    load_settings($urandom_range(150, 600), $urandom_range(0, 4095),
                                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                                  $urandom_range(0, 40), $urandom_range(0, 3000),
                                  $urandom_range(0, 65535), $urandom_range(0, 10));
        endcase
    endtask

    // mostly a slow drift around the target, some hits near the bypass edges, some noise
    function automatic int pick_temp();
        int r;
        int t;
        int step;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            step = int'($urandom_range(0, 8)) - 4;
            if ($urandom_range(0, 3) == 0)
                step += (walk < tgt_now) ? 3 : -3;
            t = walk + step;
        end
        else if (r < 85)
            t = tgt_now + int'($urandom_range(0, 2 * thr_now + 60)) - (thr_now + 30);
        else
            t = int'($urandom_range(0, 1535)) - 512;
        if (t < -512)
            t = -512;
        if (t > 1023)
            t = 1023;
        if (r < 60)
            walk = t;
        return t;
    endfunction

    initial
    begin
        int ph;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_temps[k])
            send_temp(directed_temps[k]);
        for (ph = 0; ph < PHASES; ph++)
        begin
            quiesce();
            if (ph > 0)
                pick_settings(ph);
            pace = pace_t'(ph % 4);
            walk = tgt_now - int'($urandom_range(0, 80));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while samples keep coming, then a full drain
                if (ph == 0 && n == 40)
                    hold_req = 1'b1;
                if (ph == 0 && n == 90)
                    quiesce();
                send_temp(pick_temp());
            end
        end
        quiesce();
        if (fail_count == 0)
            $display("** heater_pid_with_bypass: PASSED **");
        else
            $display("** heater_pid_with_bypass: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
design/hpid_pkg.sv
design/hpid_update.sv
design/hpid_mac.sv
design/heater_pid_with_bypass.sv
dv/heater_drive_checker.sv
dv/heater_pid_with_bypass_tb.sv
